@@ design/dtb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and codes for the deadline timer bank.
// No dependencies; every other file imports this package.
package dtb_pkg;

   localparam int TIMER_IDX_W = 4;
   localparam int KIND_W      = 2;
   localparam int DELAY_W     = 31;
   localparam int NOW_W       = 47;
   localparam int TIME_W      = 48;
   localparam int WINDOW_W    = 22;
   localparam int SLACK_W     = 6;
   localparam int SEC_W       = 38;
   localparam int CSR_IDX_W   = 1;

   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

   localparam logic RES_EXPIRY  = 1'b0;
   localparam logic RES_SUMMARY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SLACK  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 1'd1;

   localparam logic [SLACK_W-1:0] SLACK_RESET = 6'd12;
   localparam logic [DELAY_W-1:0] DELAY_MAX   = 31'h7FFF_FFFF;

   localparam int MS_PER_S  = 1000;
   localparam int MS_ROUND  = 999;
   localparam int DIV_W     = 48;
   localparam int DIV_BITS  = 8;
   localparam int DIV_STEPS = DIV_W / DIV_BITS;
   localparam int DIV_REM_W = 10;
   localparam int DIV_CNT_W = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DELAY,
      ST_ROUND,
      ST_DIV,
      ST_SUM
   } dtb_state_type;

   typedef struct packed {
      logic              any;
      logic [TIME_W-1:0] earliest;
   } dtb_carry_type;

   typedef struct packed {
      logic             step;
      logic             tick;
      logic [NOW_W-1:0] now_ms;
   } dtb_ctl_type;

   typedef struct packed {
      logic              start;
      logic              stop;
      logic [TIME_W-1:0] deadline;
   } dtb_wr_type;

   typedef struct packed {
      logic                   result_kind;
      logic [TIMER_IDX_W-1:0] expired_index;
      logic                   wake_valid;
      logic [DELAY_W-1:0]     wake_delay_ms;
      logic [WINDOW_W-1:0]    window_low_s;
      logic [WINDOW_W-1:0]    window_high_s;
      logic                   coarse_reprogram;
      logic                   last;
   } dtb_rsp_type;

endpackage

@@ design/dtb_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces: request words in, result words out.
// Depends on dtb_pkg for field widths.
interface dtb_req_if import dtb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      kind;
   logic [TIMER_IDX_W-1:0] timer_index;
   logic [DELAY_W-1:0]     delay_ms;
   logic [NOW_W-1:0]       now_ms;

   modport source (output valid, kind, timer_index, delay_ms, now_ms, input ready);
   modport sink   (input valid, kind, timer_index, delay_ms, now_ms, output ready);
endinterface

interface dtb_rsp_if import dtb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   result_kind;
   logic [TIMER_IDX_W-1:0] expired_index;
   logic                   wake_valid;
   logic [DELAY_W-1:0]     wake_delay_ms;
   logic [WINDOW_W-1:0]    window_low_s;
   logic [WINDOW_W-1:0]    window_high_s;
   logic                   coarse_reprogram;
   logic                   last;

   modport source (output valid, result_kind, expired_index, wake_valid, wake_delay_ms,
                   window_low_s, window_high_s, coarse_reprogram, last, input ready);
   modport sink   (input valid, result_kind, expired_index, wake_valid, wake_delay_ms,
                   window_low_s, window_high_s, coarse_reprogram, last, output ready);
endinterface

@@ design/dtb_cell.sv @@
`timescale 1ns / 1ps
// One timer cell: deadline and armed flag, expiry check and earliest-deadline merge.
// Depends on dtb_pkg; chained by the top level.
module dtb_cell import dtb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dtb_ctl_type   ctl,
   input  dtb_wr_type    wr,
   input  logic          sel,
   input  logic          tok_in,
   output logic          tok_out,
   input  dtb_carry_type carry_in,
   output dtb_carry_type carry_out,
   output logic          hit
);

   logic              armed_ff;
   logic [TIME_W-1:0] deadline_ff;
   logic              tok_ff;
   dtb_carry_type     carry_ff;
   dtb_carry_type     carry_in_next;
   logic              active;
   logic              due;
   logic              armed_after;
   logic              take;

   assign active      = ctl.step & tok_in;
   assign due         = armed_ff & ({1'b0, ctl.now_ms} >= deadline_ff);
   assign hit         = active & ctl.tick & due;
   assign armed_after = armed_ff & ~(ctl.tick & due);
   assign take        = armed_after & (~carry_in.any | (deadline_ff < carry_in.earliest));

   always_comb begin
      carry_in_next.any      = carry_in.any | armed_after;
      carry_in_next.earliest = take ? deadline_ff : carry_in.earliest;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         if (wr.start & sel) begin
            armed_ff <= 1'b1;
         end else if (wr.stop & sel) begin
            armed_ff <= 1'b0;
         end else if (hit) begin
            armed_ff <= 1'b0;
         end
         if (ctl.step) begin
            tok_ff <= tok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.start & sel) begin
         deadline_ff <= wr.deadline;
      end
      if (active) begin
         carry_ff <= carry_in_next;
      end
   end

   assign tok_out   = tok_ff;
   assign carry_out = carry_ff;

endmodule

@@ design/dtb_div1000.sv @@
`timescale 1ns / 1ps
// Restoring divide by one thousand, eight quotient bits per cycle.
// Depends on dtb_pkg.
module dtb_div1000 import dtb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   output logic             busy,
   output logic [DIV_W-1:0] quotient
);

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_REM_W-1:0] rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIV_REM_W-1:0] rem_in;
   logic [DIV_W-1:0]     quo_in;

   always_comb begin
      logic [DIV_REM_W:0] trial;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int j = 0; j < DIV_BITS; j++) begin
         trial  = {rem_in, quo_in[DIV_W-1]};
         quo_in = {quo_in[DIV_W-2:0], 1'b0};
         if (trial >= (DIV_REM_W+1)'(MS_PER_S)) begin
            trial     = trial - (DIV_REM_W+1)'(MS_PER_S);
            quo_in[0] = 1'b1;
         end
         rem_in = trial[DIV_REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

@@ design/deadline_timer_bank_unit.sv @@
`timescale 1ns / 1ps
// Deadline timer bank: chain of timer cells, divide-by-thousand unit, result register.
// Depends on dtb_pkg, dtb_if, dtb_cell and dtb_div1000.
//
//   channel   direction  handshake        content
//   req_ch    in         valid / ready    kind, timer_index, delay_ms, now_ms
//   rsp_ch    out        valid / ready    expiry or schedule word
//   csr_*     in         write enable     wake_slack_s, coarse_wake_enabled
//
// On each request a token walks the cell chain one cell a cycle while the result
// register has room, then the divide unit turns the wake delay into seconds.
// A new request is taken only once the schedule word is in the result register.
// A full result register holds the chain and the schedule step until it drains.
// Reset is synchronous: all timers disarmed, coarse wake cleared, slack 12.
module deadline_timer_bank_unit import dtb_pkg::*; #(
   parameter int TIMERS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   dtb_req_if.sink              req_ch,
   dtb_rsp_if.source            rsp_ch,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SLACK_W-1:0]   csr_wdata
);

   localparam int POS_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;

   dtb_state_type        state_ff, state_in;
   logic [SLACK_W-1:0]   slack_ff;
   logic                 enable_ff;
   logic [KIND_W-1:0]    kind_ff;
   logic [NOW_W-1:0]     now_ff;
   logic                 launch_ff;
   logic [POS_W-1:0]     pos_ff;
   logic                 any_ff;
   logic                 tset_ff;
   logic [DELAY_W-1:0]   wd_ff;
   logic [SEC_W-1:0]     nowsec_ff;
   logic [WINDOW_W-1:0]  lo_ff;
   logic                 coarse_set_ff;
   logic [SEC_W-1:0]     coarse_sec_ff;
   logic                 rsp_valid_ff;
   dtb_rsp_type          rsp_word_ff;
   dtb_rsp_type          rsp_word_in;

   logic                 accept;
   logic                 out_free;
   logic                 step;
   logic                 div_start;
   logic [DIV_W-1:0]     div_dividend;
   logic                 div_busy;
   logic [DIV_W-1:0]     div_quotient;
   logic                 wd_load;
   logic                 lo_load;
   logic                 sum_fire;
   logic                 hit_any;
   logic                 last_tok_in;
   logic [DELAY_W-1:0]   wd_next;
   logic [TIME_W-1:0]    now_ext;
   logic [TIME_W-1:0]    diff;
   logic [SEC_W-1:0]     sec_next;
   logic                 rep;
   logic [WINDOW_W-1:0]  hi_next;
   logic [6:0]           idx_wide;

   dtb_ctl_type          ctl;
   dtb_wr_type           wr;
   logic [TIMERS-1:0]    sel_v;
   logic [TIMERS-1:0]    tok_in_v;
   logic [TIMERS-1:0]    tok_out_v;
   logic [TIMERS-1:0]    hit_v;
   dtb_carry_type        carry_in_a  [TIMERS];
   dtb_carry_type        carry_out_a [TIMERS];

   assign req_ch.ready = (state_ff == ST_IDLE) & ~reset;
   assign accept       = req_ch.valid & req_ch.ready;
   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;

   always_comb begin
      ctl.step   = step;
      ctl.tick   = (kind_ff == KIND_TICK);
      ctl.now_ms = now_ff;
      wr.start    = accept & (req_ch.kind == KIND_START);
      wr.stop     = accept & (req_ch.kind == KIND_STOP);
      wr.deadline = TIME_W'(req_ch.now_ms) + TIME_W'(req_ch.delay_ms);
   end

   for (genvar i = 0; i < TIMERS; i++) begin : g_cell
      assign sel_v[i] = (7'(req_ch.timer_index) == 7'(i));
      if (i == 0) begin : g_head
         assign tok_in_v[i]   = launch_ff;
         assign carry_in_a[i] = '0;
      end else begin : g_link
         assign tok_in_v[i]   = tok_out_v[i-1];
         assign carry_in_a[i] = carry_out_a[i-1];
      end
      dtb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .wr        (wr),
         .sel       (sel_v[i]),
         .tok_in    (tok_in_v[i]),
         .tok_out   (tok_out_v[i]),
         .carry_in  (carry_in_a[i]),
         .carry_out (carry_out_a[i]),
         .hit       (hit_v[i])
      );
   end

   assign hit_any     = |hit_v;
   assign last_tok_in = tok_in_v[TIMERS-1];

   dtb_div1000 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   always_comb begin
      now_ext = {1'b0, now_ff};
      diff    = carry_out_a[TIMERS-1].earliest - now_ext;
      if (!carry_out_a[TIMERS-1].any || (carry_out_a[TIMERS-1].earliest <= now_ext)) begin
         wd_next = '0;
      end else if (|diff[TIME_W-1:DELAY_W]) begin
         wd_next = DELAY_MAX;
      end else begin
         wd_next = diff[DELAY_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      step         = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      wd_load      = 1'b0;
      lo_load      = 1'b0;
      sum_fire     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               div_start    = 1'b1;
               div_dividend = DIV_W'(req_ch.now_ms) + DIV_W'(MS_ROUND);
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               step = 1'b1;
               if (last_tok_in) begin
                  state_in = ST_DELAY;
               end
            end
         end
         ST_DELAY: begin
            if (!div_busy) begin
               wd_load  = 1'b1;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(wd_ff) + DIV_W'(MS_ROUND);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (!div_busy) begin
               lo_load  = 1'b1;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (out_free) begin
               sum_fire = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slack_ff  <= SLACK_RESET;
         enable_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SLACK:  slack_ff  <= csr_wdata;
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff <= 1'b0;
         pos_ff    <= '0;
      end else if (accept) begin
         launch_ff <= 1'b1;
         pos_ff    <= '0;
      end else if (step) begin
         launch_ff <= 1'b0;
         pos_ff    <= pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_ch.kind;
         now_ff  <= req_ch.now_ms;
      end
      if (wd_load) begin
         wd_ff     <= wd_next;
         any_ff    <= carry_out_a[TIMERS-1].any;
         tset_ff   <= carry_out_a[TIMERS-1].any & enable_ff;
         nowsec_ff <= div_quotient[SEC_W-1:0];
      end
      if (lo_load) begin
         lo_ff <= tset_ff ? div_quotient[WINDOW_W-1:0] : '0;
      end
   end

   assign sec_next = nowsec_ff + SEC_W'(lo_ff);
   assign rep      = (tset_ff != coarse_set_ff) | (tset_ff & (sec_next != coarse_sec_ff));
   assign hi_next  = tset_ff ? lo_ff + WINDOW_W'(slack_ff) : '0;
   assign idx_wide = 7'(pos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         coarse_set_ff <= 1'b0;
         coarse_sec_ff <= '0;
      end else if (sum_fire & rep) begin
         coarse_set_ff <= tset_ff;
         coarse_sec_ff <= tset_ff ? sec_next : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((step & hit_any) | sum_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      rsp_word_in = '0;
      if (sum_fire) begin
         rsp_word_in.result_kind      = RES_SUMMARY;
         rsp_word_in.wake_valid       = any_ff;
         rsp_word_in.wake_delay_ms    = wd_ff;
         rsp_word_in.window_low_s     = lo_ff;
         rsp_word_in.window_high_s    = hi_next;
         rsp_word_in.coarse_reprogram = rep;
         rsp_word_in.last             = 1'b1;
      end else begin
         rsp_word_in.result_kind      = RES_EXPIRY;
         rsp_word_in.expired_index    = idx_wide[TIMER_IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if ((step & hit_any) | sum_fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.result_kind      = rsp_word_ff.result_kind;
   assign rsp_ch.expired_index    = rsp_word_ff.expired_index;
   assign rsp_ch.wake_valid       = rsp_word_ff.wake_valid;
   assign rsp_ch.wake_delay_ms    = rsp_word_ff.wake_delay_ms;
   assign rsp_ch.window_low_s     = rsp_word_ff.window_low_s;
   assign rsp_ch.window_high_s    = rsp_word_ff.window_high_s;
   assign rsp_ch.coarse_reprogram = rsp_word_ff.coarse_reprogram;
   assign rsp_ch.last             = rsp_word_ff.last;

endmodule

@@ test/deadline_timer_bank_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for deadline_timer_bank_unit: drives random and directed commands,
// predicts every expiry and schedule word, and compares them field by field.
// Depends on dtb_pkg, dtb_if and the design files.
module deadline_timer_bank_unit_tb;
   import dtb_pkg::*;

   localparam int TIMERS = 16;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 2 * (TIMERS + 11);
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam logic [NOW_W-1:0] NOW_MAX = {NOW_W{1'b1}};

   typedef struct packed {
      logic [KIND_W-1:0]      kind;
      logic [TIMER_IDX_W-1:0] timer_index;
      logic [DELAY_W-1:0]     delay_ms;
      logic [NOW_W-1:0]       now_ms;
   } timer_cmd_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SLACK_W-1:0] csr_wdata;

   dtb_req_if req_ch ();
   dtb_rsp_if rsp_ch ();

   deadline_timer_bank_unit #(.TIMERS(TIMERS)) uut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   timer_cmd_type outgoing_cmds[$];
   dtb_rsp_type owed_words[$];
   logic cmd_taken;
   logic fault_seen;
   int send_idle_pct;
   int stall_pct;
   longint unsigned cycle_count;
   logic [NOW_W-1:0] stim_now;

   // timer bank image
   logic [TIME_W-1:0] bank_deadline [TIMERS];
   logic [TIMERS-1:0] bank_armed;
   logic [TIME_W-1:0] coarse_time;
   logic coarse_set;
   logic [SLACK_W-1:0] cfg_slack;
   logic cfg_coarse_en;

   dtb_rsp_type owed;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic advance_timer_bank(input timer_cmd_type cmd);
      dtb_rsp_type word;
      logic [TIME_W-1:0] earliest;
      logic any_armed;
      logic new_set;
      logic reprogram;
      longint unsigned now64;
      longint unsigned wait_ms;
      longint unsigned low_s;
      longint unsigned high_s;
      longint unsigned wake_at;
      int i;
      now64 = cmd.now_ms;
      any_armed = 1'b0;
      earliest = '0;
      wait_ms = 0;
      low_s = 0;
      high_s = 0;
      wake_at = 0;
      new_set = 1'b0;
      case (cmd.kind)
         KIND_START: begin
            bank_deadline[cmd.timer_index] = TIME_W'(cmd.now_ms) + TIME_W'(cmd.delay_ms);
            bank_armed[cmd.timer_index] = 1'b1;
         end
         KIND_STOP: begin
            bank_armed[cmd.timer_index] = 1'b0;
         end
         KIND_TICK: begin
            for (i = 0; i < TIMERS; i++) begin
               if (bank_armed[i] && TIME_W'(cmd.now_ms) >= bank_deadline[i]) begin
                  bank_armed[i] = 1'b0;
                  word = '0;
                  word.result_kind = RES_EXPIRY;
                  word.expired_index = TIMER_IDX_W'(i);
                  owed_words.push_back(word);
               end
            end
         end
         default: begin
         end
      endcase
      for (i = 0; i < TIMERS; i++) begin
         if (bank_armed[i] && (!any_armed || bank_deadline[i] < earliest)) begin
            earliest = bank_deadline[i];
            any_armed = 1'b1;
         end
      end
      if (any_armed) begin
         wait_ms = (earliest > now64) ? earliest - now64 : 0;
         if (wait_ms > DELAY_MAX) wait_ms = DELAY_MAX;
         if (cfg_coarse_en) begin
            low_s = (wait_ms + MS_ROUND) / MS_PER_S;
            high_s = low_s + cfg_slack;
            wake_at = now64 + low_s * MS_PER_S + MS_ROUND;
            wake_at -= wake_at % MS_PER_S;
            wake_at &= 64'hFFFF_FFFF_FFFF;
            new_set = 1'b1;
         end
      end
      reprogram = (new_set != coarse_set) || (new_set && wake_at != coarse_time);
      if (reprogram) begin
         coarse_set = new_set;
         coarse_time = new_set ? TIME_W'(wake_at) : '0;
      end
      word = '0;
      word.result_kind = RES_SUMMARY;
      word.wake_valid = any_armed;
      word.wake_delay_ms = wait_ms[DELAY_W-1:0];
      word.window_low_s = low_s[WINDOW_W-1:0];
      word.window_high_s = high_s[WINDOW_W-1:0];
      word.coarse_reprogram = reprogram;
      word.last = 1'b1;
      owed_words.push_back(word);
   endtask

   function automatic void check_field(input string field, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
         fault_seen = 1'b1;
      end
   endfunction

   function automatic void push_cmd(input logic [KIND_W-1:0] kind,
                                    input logic [TIMER_IDX_W-1:0] idx,
                                    input logic [DELAY_W-1:0] delay,
                                    input logic [NOW_W-1:0] now);
      outgoing_cmds.push_back(timer_cmd_type'{kind, idx, delay, now});
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || cmd_taken) begin
         if (outgoing_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.kind <= outgoing_cmds[0].kind;
            req_ch.timer_index <= outgoing_cmds[0].timer_index;
            req_ch.delay_ms <= outgoing_cmds[0].delay_ms;
            req_ch.now_ms <= outgoing_cmds[0].now_ms;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // accepted commands: advance the bank image
   always @(posedge clock) begin
      if (reset) begin
         cmd_taken <= 1'b0;
      end else begin
         cmd_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            outgoing_cmds.delete(0);
            advance_timer_bank(timer_cmd_type'{req_ch.kind, req_ch.timer_index,
                                               req_ch.delay_ms, req_ch.now_ms});
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (owed_words.size() == 0) begin
            $display("%0t ns: result word with none owed, kind %0h index %0h",
                     $time, rsp_ch.result_kind, rsp_ch.expired_index);
            fault_seen = 1'b1;
         end else begin
            owed = owed_words.pop_front();
            check_field("result_kind", owed.result_kind, rsp_ch.result_kind);
            check_field("expired_index", owed.expired_index, rsp_ch.expired_index);
            check_field("wake_valid", owed.wake_valid, rsp_ch.wake_valid);
            check_field("wake_delay_ms", owed.wake_delay_ms, rsp_ch.wake_delay_ms);
            check_field("window_low_s", owed.window_low_s, rsp_ch.window_low_s);
            check_field("window_high_s", owed.window_high_s, rsp_ch.window_high_s);
            check_field("coarse_reprogram", owed.coarse_reprogram, rsp_ch.coarse_reprogram);
            check_field("last", owed.last, rsp_ch.last);
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SLACK_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_SLACK) cfg_slack = value;
      else cfg_coarse_en = value[0];
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (outgoing_cmds.size() != 0 || owed_words.size() != 0);
   endtask

   task automatic queue_random_cmds(input int count);
      logic [KIND_W-1:0] kind;
      logic [DELAY_W-1:0] delay;
      int made;
      int pick;
      int span;
      int i;
      made = 0;
      while (made < count) begin
         if ($urandom_range(99) < 8) begin
            // arm a run of timers close together, then sweep them with one tick
            span = $urandom_range(4, TIMERS);
            for (i = 0; i < span; i++) begin
               push_cmd(KIND_START, TIMER_IDX_W'(i), DELAY_W'($urandom_range(0, 300)),
                        stim_now);
            end
            stim_now += $urandom_range(300, 500);
            push_cmd(KIND_TICK, TIMER_IDX_W'($urandom), DELAY_W'($urandom), stim_now);
            made += span + 1;
         end else begin
            pick = $urandom_range(99);
            if (pick < 3) stim_now = NOW_W'({$urandom, $urandom});
            else if (pick < 6) stim_now -= $urandom_range(0, 5000);
            else stim_now += $urandom_range(0, 40);
            pick = $urandom_range(99);
            if (pick < 40) kind = KIND_START;
            else if (pick < 75) kind = KIND_TICK;
            else if (pick < 94) kind = KIND_STOP;
            else kind = KIND_SPARE;
            if (kind == KIND_TICK) stim_now += $urandom_range(0, 3000);
            pick = $urandom_range(99);
            if (pick < 60) delay = DELAY_W'($urandom_range(0, 4000));
            else if (pick < 85) delay = DELAY_W'($urandom_range(0, 200000));
            else delay = DELAY_W'($urandom);
            push_cmd(kind, TIMER_IDX_W'($urandom), delay, stim_now);
            if (kind != KIND_SPARE) made++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_TICK;
      req_ch.timer_index = '0;
      req_ch.delay_ms = '0;
      req_ch.now_ms = '0;
      rsp_ch.ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_SLACK;
      csr_wdata = '0;
      cmd_taken = 1'b0;
      fault_seen = 1'b0;
      cycle_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      stim_now = '0;
      bank_armed = '0;
      for (int i = 0; i < TIMERS; i++) bank_deadline[i] = '0;
      coarse_time = '0;
      coarse_set = 1'b0;
      cfg_slack = SLACK_RESET;
      cfg_coarse_en = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset configuration: coarse wake off, default slack
      queue_random_cmds(30);
      wait_drained();

      write_csr(CSR_SLACK, 6'd63);
      write_csr(CSR_ENABLE, {5'($urandom), 1'b1});

      stim_now = 47'd5000;
      push_cmd(KIND_START, 4'd0, 31'd0, stim_now);
      push_cmd(KIND_START, 4'd15, DELAY_MAX, stim_now);
      push_cmd(KIND_START, 4'd15, 31'd1500, stim_now);
      push_cmd(KIND_STOP, 4'd7, 31'd0, stim_now);
      push_cmd(KIND_SPARE, 4'd15, DELAY_MAX, stim_now);
      push_cmd(KIND_START, 4'd3, 31'd999, stim_now);
      push_cmd(KIND_START, 4'd4, 31'd1000, stim_now);
      push_cmd(KIND_START, 4'd5, 31'd1001, stim_now);
      push_cmd(KIND_TICK, 4'd0, 31'd0, stim_now);
      push_cmd(KIND_TICK, 4'd0, 31'd0, stim_now + 999);
      push_cmd(KIND_TICK, 4'd9, 31'd123, stim_now + 1001);
      push_cmd(KIND_STOP, 4'd15, 31'd0, stim_now + 1001);
      push_cmd(KIND_TICK, 4'd0, 31'd0, stim_now + 1600);
      push_cmd(KIND_START, 4'd10, 31'd1, NOW_MAX);
      push_cmd(KIND_START, 4'd2, DELAY_MAX, NOW_MAX);
      push_cmd(KIND_START, 4'd6, 31'd0, NOW_MAX);
      push_cmd(KIND_TICK, 4'd0, 31'd0, NOW_MAX);
      // time steps back to zero: delay saturates
      push_cmd(KIND_TICK, 4'd0, 31'd0, '0);
      push_cmd(KIND_STOP, 4'd2, 31'd0, '0);
      push_cmd(KIND_STOP, 4'd10, 31'd0, '0);
      push_cmd(KIND_START, 4'd1, 31'd0, '0);
      push_cmd(KIND_TICK, 4'd0, 31'd0, '0);
      wait_drained();
      stim_now = '0;

      queue_random_cmds(60);
      wait_drained();

      write_csr(CSR_SLACK, 6'd0);
      send_idle_pct = 73;
      queue_random_cmds(60);
      wait_drained();

      write_csr(CSR_SLACK, SLACK_W'($urandom));
      write_csr(CSR_ENABLE, {5'($urandom), 1'b0});
      send_idle_pct = 0;
      stall_pct = 73;
      queue_random_cmds(60);
      wait_drained();

      write_csr(CSR_SLACK, 6'd5);
      write_csr(CSR_ENABLE, {5'($urandom), 1'b1});
      send_idle_pct = 27;
      stall_pct = 27;
      queue_random_cmds(60);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_seen) begin
         $display("Some tests failed");
      end else begin
         $display("All tests passed");
      end
      $finish;
   end

endmodule
